FILE: rtl/bps_pkg.sv
package bps_pkg;

    localparam int ADDR_BITS_DEFAULT = 32;
    localparam int FOOTER_BYTES      = 12;

    localparam int KIND_W  = 3;
    localparam int ERR_W   = 2;
    localparam int RUN_W   = 33;
    localparam int FIELD_W = 32;
    localparam int BYTE_W  = 8;
    localparam int VAR_W   = 34;
    localparam int VSUM_W  = 44;

    localparam logic [VSUM_W-1:0] LIM_SIZE = VSUM_W'(64'hFFFF_FFFF);
    localparam logic [VSUM_W-1:0] LIM_CMD  = VSUM_W'(64'h3_FFFF_FFFF);
    localparam logic [VSUM_W-1:0] LIM_REL  = VSUM_W'(64'h1_FFFF_FFFF);

    localparam logic [7:0] DATA_MASK = 8'h7F;
    localparam logic [7:0] STOP_MASK = 8'h80;
    localparam logic [2:0] VAR_MAX_SHIFT = 3'd5;

    typedef enum logic [3:0] {
        PH_MARKER    = 4'd0,
        PH_SRC_SIZE  = 4'd1,
        PH_TGT_SIZE  = 4'd2,
        PH_META_SIZE = 4'd3,
        PH_META_SKIP = 4'd4,
        PH_CMD       = 4'd5,
        PH_REL       = 4'd6,
        PH_LITERAL   = 4'd7,
        PH_FOOTER    = 4'd8,
        PH_DONE      = 4'd9,
        PH_ERROR     = 4'd10
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_HEADER      = 3'd0,
        KIND_SOURCE_READ = 3'd1,
        KIND_LITERAL     = 3'd2,
        KIND_SOURCE_COPY = 3'd3,
        KIND_TARGET_COPY = 3'd4,
        KIND_DONE        = 3'd5,
        KIND_ERROR       = 3'd6
    } kind_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE       = 2'd0,
        ERR_MARKER     = 2'd1,
        ERR_OVERFLOW   = 2'd2,
        ERR_RANGE      = 2'd3
    } err_t;

    typedef enum logic [1:0] {
        CMD_SOURCE_READ = 2'd0,
        CMD_TARGET_READ = 2'd1,
        CMD_SOURCE_COPY = 2'd2,
        CMD_TARGET_COPY = 2'd3
    } cmd_t;

    typedef struct packed {
        kind_t               kind;
        err_t                error_code;
        logic [RUN_W-1:0]    run_length;
        logic [FIELD_W-1:0]  read_address;
        logic [FIELD_W-1:0]  write_address;
        logic [BYTE_W-1:0]   literal_byte;
        logic [FIELD_W-1:0]  header_src_size;
        logic [FIELD_W-1:0]  header_tgt_size;
        logic [FIELD_W-1:0]  expected_crc;
    } result_t;

    typedef struct packed {
        logic               fail;
        logic               done;
        logic [2:0]         shift;
        logic [VAR_W-1:0]   value;
    } varint_t;

    // marker byte for a position
    function automatic logic [7:0] marker_byte(input logic [1:0] idx);
        logic [7:0] m;
        case (idx)
            2'd0:    m = 8'h42;
            2'd1:    m = 8'h50;
            2'd2:    m = 8'h53;
            default: m = 8'h31;
        endcase
        return m;
    endfunction

    // one byte of an offset-style varint
    function automatic varint_t varint_feed(input logic [VAR_W-1:0] value,
                                            input logic [2:0] shift,
                                            input logic [7:0] b,
                                            input logic [VSUM_W-1:0] limit);
        varint_t          r;
        logic [5:0]       amt;
        logic [5:0]       amt_next;
        logic [VSUM_W-1:0] sum1;
        logic [VSUM_W-1:0] sum2;
        amt      = 6'({shift, 3'b000}) - 6'(shift);
        amt_next = amt + 6'd7;
        sum1     = VSUM_W'(value) + (VSUM_W'(b & DATA_MASK) << amt);
        sum2     = sum1 + (VSUM_W'(1) << amt_next);
        r.fail   = 1'b0;
        r.done   = 1'b0;
        r.shift  = shift;
        r.value  = VAR_W'(sum1);
        if (shift > VAR_MAX_SHIFT || sum1 > limit) begin
            r.fail = 1'b1;
        end else if ((b & STOP_MASK) != 8'h00) begin
            r.done = 1'b1;
        end else if (sum2 > limit) begin
            r.fail = 1'b1;
        end else begin
            r.shift = shift + 3'd1;
            r.value = VAR_W'(sum2);
        end
        return r;
    endfunction

endpackage

FILE: rtl/bps_in_if.sv
interface bps_in_if;
    logic                       valid;
    logic                       ready;
    logic [bps_pkg::BYTE_W-1:0] patch_byte;
    logic                       restart;

    modport source (output valid, output patch_byte, output restart, input ready);
    modport sink (input valid, input patch_byte, input restart, output ready);
endinterface

FILE: rtl/bps_out_if.sv
interface bps_out_if;
    logic                        valid;
    logic                        ready;
    logic [bps_pkg::KIND_W-1:0]  kind;
    logic [bps_pkg::ERR_W-1:0]   error_code;
    logic [bps_pkg::RUN_W-1:0]   run_length;
    logic [bps_pkg::FIELD_W-1:0] read_address;
    logic [bps_pkg::FIELD_W-1:0] write_address;
    logic [bps_pkg::BYTE_W-1:0]  literal_byte;
    logic [bps_pkg::FIELD_W-1:0] header_src_size;
    logic [bps_pkg::FIELD_W-1:0] header_tgt_size;
    logic [bps_pkg::FIELD_W-1:0] expected_crc;

    modport source (output valid, output kind, output error_code, output run_length,
                    output read_address, output write_address, output literal_byte,
                    output header_src_size, output header_tgt_size, output expected_crc,
                    input ready);
    modport sink (input valid, input kind, input error_code, input run_length,
                  input read_address, input write_address, input literal_byte,
                  input header_src_size, input header_tgt_size, input expected_crc,
                  output ready);
endinterface

FILE: rtl/bps_patch_stream_decoder_core.sv
// a result beat is registered into the result register, or into the skid entry while the result register is held
// throughput: one patch byte per cycle while the skid entry is empty; parse state updates in the accept cycle
// a two-entry result buffer (result register plus skid) keeps input flowing
// while one result waits on the sink
// reset (rst_n low, async): parser in marker phase, all offsets zero, buffer empty
module bps_patch_stream_decoder_core #(
    parameter int ADDR_BITS = bps_pkg::ADDR_BITS_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_write_en,
    input  logic [31:0]     cfg_write_data,
    bps_in_if.sink          patch,
    bps_out_if.source       result
);

    localparam int WW = ((ADDR_BITS > 33) ? ADDR_BITS : 33) + 3;
    localparam int OW = ADDR_BITS + 1;
    localparam logic [WW-1:0] ADDR_LIMIT = WW'(1) << ADDR_BITS;

    // parse state
    bps_pkg::phase_t              phase_reg, phase_next;
    logic [31:0]                  pos_reg, pos_next;
    logic [bps_pkg::VAR_W-1:0]    vval_reg, vval_next;
    logic [2:0]                   vidx_reg, vidx_next;
    logic [1:0]                   pcmd_reg, pcmd_next;
    logic [bps_pkg::RUN_W-1:0]    plen_reg, plen_next;
    logic [bps_pkg::RUN_W-1:0]    rem_reg, rem_next;
    logic [OW-1:0]                oo_reg, oo_next;
    logic [ADDR_BITS-1:0]         srel_reg, srel_next;
    logic [ADDR_BITS-1:0]         trel_reg, trel_next;
    logic [31:0]                  hss_reg, hss_next;
    logic [3:0]                   fshift_reg, fshift_next;
    logic [31:0]                  plength_reg;

    // result buffer
    logic                         main_valid_reg, skid_valid_reg;
    bps_pkg::result_t             main_reg, skid_reg;

    logic                         accept, pop;
    logic                         has_res;
    bps_pkg::result_t             res;

    assign accept       = patch.valid & patch.ready;
    assign pop          = main_valid_reg & result.ready;
    assign patch.ready  = ~skid_valid_reg;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            plength_reg <= '0;
        end else if (cfg_write_en) begin
            plength_reg <= cfg_write_data;
        end
    end

    // decode one byte
    always_comb
    begin
        bps_pkg::varint_t  vf;
        logic [31:0]       pos;
        logic [31:0]       footer_start;
        logic [7:0]        b;
        logic [bps_pkg::RUN_W-1:0] len;
        logic [WW-1:0]     wlen;
        logic [WW-1:0]     woo;
        logic [WW-1:0]     delta;
        logic [WW-1:0]     base;
        logic [WW-1:0]     rel;
        logic              neg;
        logic              footer;
        bps_pkg::err_t     err;

        phase_next  = phase_reg;
        pos_next    = pos_reg;
        vval_next   = vval_reg;
        vidx_next   = vidx_reg;
        pcmd_next   = pcmd_reg;
        plen_next   = plen_reg;
        rem_next    = rem_reg;
        oo_next     = oo_reg;
        srel_next   = srel_reg;
        trel_next   = trel_reg;
        hss_next    = hss_reg;
        fshift_next = fshift_reg;
        has_res     = 1'b0;
        res         = '0;
        footer      = 1'b0;
        b           = patch.patch_byte;
        vf          = '0;
        len         = '0;
        wlen        = '0;
        delta       = '0;
        base        = '0;
        rel         = '0;
        neg         = 1'b0;
        err         = bps_pkg::ERR_NONE;

        // restart clears parse state before this byte
        if (patch.restart) begin
            phase_next  = bps_pkg::PH_MARKER;
            pos_next    = '0;
            vval_next   = '0;
            vidx_next   = '0;
            pcmd_next   = '0;
            plen_next   = '0;
            rem_next    = '0;
            oo_next     = '0;
            srel_next   = '0;
            trel_next   = '0;
            hss_next    = '0;
            fshift_next = '0;
        end

        pos          = pos_next;
        footer_start = (plength_reg >= 32'(bps_pkg::FOOTER_BYTES))
                     ? plength_reg - 32'(bps_pkg::FOOTER_BYTES) : 32'd0;
        woo          = WW'(oo_next);

        if (phase_next != bps_pkg::PH_DONE && phase_next != bps_pkg::PH_ERROR) begin
            pos_next = pos + 32'd1;
            case (phase_next)
                bps_pkg::PH_MARKER:
                begin
                    if (b != bps_pkg::marker_byte(pos[1:0])) begin
                        has_res = 1'b1;
                    end else if (pos >= 32'd3) begin
                        phase_next = bps_pkg::PH_SRC_SIZE;
                        vval_next  = '0;
                        vidx_next  = '0;
                    end
                    res.error_code = bps_pkg::ERR_MARKER;
                end
                bps_pkg::PH_SRC_SIZE, bps_pkg::PH_TGT_SIZE, bps_pkg::PH_META_SIZE:
                begin
                    vf = bps_pkg::varint_feed(vval_next, vidx_next, b, bps_pkg::LIM_SIZE);
                    vval_next = vf.value;
                    vidx_next = vf.shift;
                    res.error_code = bps_pkg::ERR_OVERFLOW;
                    if (vf.fail) begin
                        has_res = 1'b1;
                    end else if (vf.done) begin
                        vval_next = '0;
                        vidx_next = '0;
                        if (phase_next == bps_pkg::PH_SRC_SIZE) begin
                            hss_next   = vf.value[31:0];
                            phase_next = bps_pkg::PH_TGT_SIZE;
                        end else if (phase_next == bps_pkg::PH_TGT_SIZE) begin
                            phase_next          = bps_pkg::PH_META_SIZE;
                            has_res             = 1'b1;
                            res.kind            = bps_pkg::KIND_HEADER;
                            res.error_code      = bps_pkg::ERR_NONE;
                            res.header_src_size = hss_next;
                            res.header_tgt_size = vf.value[31:0];
                        end else begin
                            rem_next   = bps_pkg::RUN_W'(vf.value);
                            phase_next = (vf.value != '0) ? bps_pkg::PH_META_SKIP
                                                          : bps_pkg::PH_CMD;
                        end
                    end
                end
                bps_pkg::PH_META_SKIP:
                begin
                    rem_next = rem_next - 1'b1;
                    if (rem_next == '0) begin
                        phase_next = bps_pkg::PH_CMD;
                    end
                end
                bps_pkg::PH_CMD:
                begin
                    if (vidx_next == 3'd0 && pos >= footer_start) begin
                        footer      = 1'b1;
                        fshift_next = '0;
                        vval_next   = '0;
                        vidx_next   = '0;
                        phase_next  = bps_pkg::PH_FOOTER;
                    end else begin
                        vf = bps_pkg::varint_feed(vval_next, vidx_next, b, bps_pkg::LIM_CMD);
                        vval_next = vf.value;
                        vidx_next = vf.shift;
                        res.error_code = bps_pkg::ERR_OVERFLOW;
                        if (vf.fail) begin
                            has_res = 1'b1;
                        end else if (vf.done) begin
                            len       = bps_pkg::RUN_W'(vf.value >> 2) + 1'b1;
                            wlen      = WW'(len);
                            pcmd_next = vf.value[1:0];
                            plen_next = len;
                            vval_next = '0;
                            vidx_next = '0;
                            res.error_code = bps_pkg::ERR_RANGE;
                            case (bps_pkg::cmd_t'(vf.value[1:0]))
                                bps_pkg::CMD_SOURCE_READ:
                                begin
                                    has_res = 1'b1;
                                    if (woo + wlen <= ADDR_LIMIT
                                        && woo + wlen <= WW'(hss_next)) begin
                                        oo_next           = OW'(woo + wlen);
                                        res.kind          = bps_pkg::KIND_SOURCE_READ;
                                        res.error_code    = bps_pkg::ERR_NONE;
                                        res.run_length    = len;
                                        res.read_address  = 32'(woo);
                                        res.write_address = 32'(woo);
                                    end
                                end
                                bps_pkg::CMD_TARGET_READ:
                                begin
                                    if (woo + wlen > ADDR_LIMIT) begin
                                        has_res = 1'b1;
                                    end else begin
                                        rem_next   = len;
                                        phase_next = bps_pkg::PH_LITERAL;
                                    end
                                end
                                default:
                                begin
                                    phase_next = bps_pkg::PH_REL;
                                end
                            endcase
                        end
                    end
                end
                bps_pkg::PH_REL:
                begin
                    vf = bps_pkg::varint_feed(vval_next, vidx_next, b, bps_pkg::LIM_REL);
                    vval_next = vf.value;
                    vidx_next = vf.shift;
                    res.error_code = bps_pkg::ERR_OVERFLOW;
                    if (vf.fail) begin
                        has_res = 1'b1;
                    end else if (vf.done) begin
                        has_res   = 1'b1;
                        vval_next = '0;
                        vidx_next = '0;
                        len   = plen_next;
                        wlen  = WW'(len);
                        delta = WW'(vf.value >> 1);
                        neg   = vf.value[0];
                        base  = (pcmd_next == bps_pkg::CMD_SOURCE_COPY)
                              ? WW'(srel_next) : WW'(trel_next);
                        rel   = neg ? base - delta : base + delta;
                        res.error_code = bps_pkg::ERR_RANGE;
                        // range checks for the relative copy
                        if (woo + wlen <= ADDR_LIMIT && !(neg && delta > base)) begin
                            if (pcmd_next == bps_pkg::CMD_SOURCE_COPY) begin
                                if (rel + wlen <= WW'(hss_next)) begin
                                    srel_next      = ADDR_BITS'(rel + wlen);
                                    res.kind       = bps_pkg::KIND_SOURCE_COPY;
                                    res.error_code = bps_pkg::ERR_NONE;
                                end
                            end else if (rel < woo) begin
                                trel_next      = ADDR_BITS'(rel + wlen);
                                res.kind       = bps_pkg::KIND_TARGET_COPY;
                                res.error_code = bps_pkg::ERR_NONE;
                            end
                        end
                        if (res.error_code == bps_pkg::ERR_NONE) begin
                            oo_next           = OW'(woo + wlen);
                            phase_next        = bps_pkg::PH_CMD;
                            res.run_length    = len;
                            res.read_address  = 32'(rel);
                            res.write_address = 32'(woo);
                        end
                    end
                end
                bps_pkg::PH_LITERAL:
                begin
                    has_res           = 1'b1;
                    res.kind          = bps_pkg::KIND_LITERAL;
                    res.run_length    = bps_pkg::RUN_W'(1);
                    res.write_address = 32'(woo);
                    res.literal_byte  = b;
                    oo_next  = oo_next + 1'b1;
                    rem_next = rem_next - 1'b1;
                    if (rem_next == '0) begin
                        phase_next = bps_pkg::PH_CMD;
                    end
                end
                bps_pkg::PH_FOOTER:
                begin
                    footer = 1'b1;
                end
                default:
                begin
                    has_res        = 1'b1;
                    res.error_code = bps_pkg::ERR_RANGE;
                end
            endcase

            // footer bytes, crc little-endian at footer bytes 4..7
            if (footer) begin
                case (fshift_next)
                    4'd4:    vval_next[7:0]   = b;
                    4'd5:    vval_next[15:8]  = b;
                    4'd6:    vval_next[23:16] = b;
                    4'd7:    vval_next[31:24] = b;
                    default: vval_next = vval_next;
                endcase
                fshift_next = fshift_next + 4'd1;
                if (fshift_next >= 4'(bps_pkg::FOOTER_BYTES)) begin
                    phase_next       = bps_pkg::PH_DONE;
                    has_res          = 1'b1;
                    res.kind         = bps_pkg::KIND_DONE;
                    res.error_code   = bps_pkg::ERR_NONE;
                    res.expected_crc = vval_next[31:0];
                end
            end

            // any error result clears the payload and stops the parser
            if (has_res && res.error_code != bps_pkg::ERR_NONE) begin
                err            = res.error_code;
                res            = '0;
                res.kind       = bps_pkg::KIND_ERROR;
                res.error_code = err;
                phase_next     = bps_pkg::PH_ERROR;
            end
        end
    end

    // parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg  <= bps_pkg::PH_MARKER;
            pos_reg    <= '0;
            vval_reg   <= '0;
            vidx_reg   <= '0;
            pcmd_reg   <= '0;
            plen_reg   <= '0;
            rem_reg    <= '0;
            oo_reg     <= '0;
            srel_reg   <= '0;
            trel_reg   <= '0;
            hss_reg    <= '0;
            fshift_reg <= '0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            vval_reg   <= vval_next;
            vidx_reg   <= vidx_next;
            pcmd_reg   <= pcmd_next;
            plen_reg   <= plen_next;
            rem_reg    <= rem_next;
            oo_reg     <= oo_next;
            srel_reg   <= srel_next;
            trel_reg   <= trel_next;
            hss_reg    <= hss_next;
            fshift_reg <= fshift_next;
        end
    end

    // result buffer valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!main_valid_reg || pop) begin
            main_valid_reg <= skid_valid_reg | (accept & has_res);
            skid_valid_reg <= skid_valid_reg & accept & has_res;
        end else if (accept && has_res) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // result buffer payload
    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || pop) begin
            main_reg <= skid_valid_reg ? skid_reg : res;
            if (skid_valid_reg) begin
                skid_reg <= res;
            end
        end else if (accept && has_res) begin
            skid_reg <= res;
        end
    end

    assign result.valid           = main_valid_reg;
    assign result.kind            = main_reg.kind;
    assign result.error_code      = main_reg.error_code;
    assign result.run_length      = main_reg.run_length;
    assign result.read_address    = main_reg.read_address;
    assign result.write_address   = main_reg.write_address;
    assign result.literal_byte    = main_reg.literal_byte;
    assign result.header_src_size = main_reg.header_src_size;
    assign result.header_tgt_size = main_reg.header_tgt_size;
    assign result.expected_crc    = main_reg.expected_crc;

    // skid entry only fills behind a held result
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry valid with empty result register");

    // error beats always carry a cause
    a_error_has_code: assert property (@(posedge clk) disable iff (!rst_n)
        main_valid_reg && main_reg.kind == bps_pkg::KIND_ERROR
        |-> main_reg.error_code != bps_pkg::ERR_NONE)
        else $error("error beat without error code");

    // stopped parser stays silent until restart
    a_stopped_silent: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !patch.restart
        && (phase_reg == bps_pkg::PH_DONE || phase_reg == bps_pkg::PH_ERROR)
        |=> $stable(phase_reg) && $stable(oo_reg))
        else $error("parser moved after done or error");

    // output offset never passes the address space
    a_offset_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        WW'(oo_reg) <= ADDR_LIMIT)
        else $error("output offset past address range");

endmodule

FILE: dv/bps_decoder_checker.sv
`timescale 1ns / 1ps

module bps_decoder_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [31:0] cfg_write_data,
    bps_in_if           patch,
    bps_out_if          result,
    output int          fail_count,
    output int          beats_checked,
    output int          pending
);

    localparam longint unsigned ADDR_SPAN = 64'h1_0000_0000;
    localparam longint unsigned SIZE_MAX  = 64'hFFFF_FFFF;
    localparam longint unsigned WORD_MAX  = 64'h3_FFFF_FFFF;
    localparam longint unsigned DELTA_MAX = 64'h1_FFFF_FFFF;

    // decoder image kept by the checker
    bps_pkg::phase_t parse_phase;
    logic [31:0]     patch_len;
    logic [31:0]     byte_count;
    longint unsigned acc;
    int unsigned     acc_shift;
    logic [1:0]      cmd_code;
    longint unsigned cmd_len;
    longint unsigned left;
    longint unsigned out_pos;
    longint unsigned src_pos;
    longint unsigned tgt_pos;
    logic [31:0]     src_limit;
    int unsigned     footer_idx;

    bps_pkg::result_t expected_beats[$];

    function automatic void clear_parse();
        parse_phase = bps_pkg::PH_MARKER;
        byte_count  = '0;
        acc         = 0;
        acc_shift   = 0;
        cmd_code    = '0;
        cmd_len     = 0;
        left        = 0;
        out_pos     = 0;
        src_pos     = 0;
        tgt_pos     = 0;
        src_limit   = '0;
        footer_idx  = 0;
    endfunction

    // offset varint: 1 complete, 0 more, -1 overflow
    function automatic int take_varint(input logic [7:0] b, input longint unsigned lim);
        if (acc_shift > 5) return -1;
        acc += longint'(b & 8'h7F) << (7 * acc_shift);
        if (acc > lim) return -1;
        if (b[7]) return 1;
        acc_shift++;
        acc += 64'd1 << (7 * acc_shift);
        if (acc > lim) return -1;
        return 0;
    endfunction

    function automatic bit fits_output(input longint unsigned len);
        return out_pos <= ADDR_SPAN && len <= ADDR_SPAN - out_pos;
    endfunction

    function automatic void push_beat(input bps_pkg::kind_t k, input bps_pkg::err_t e,
                                      input longint unsigned run,
                                      input longint unsigned rd, input longint unsigned wr,
                                      input logic [7:0] lit, input longint unsigned ss,
                                      input longint unsigned ts, input longint unsigned crc);
        bps_pkg::result_t r;
        r = '0;
        r.kind            = k;
        r.error_code      = e;
        r.run_length      = run[32:0];
        r.read_address    = rd[31:0];
        r.write_address   = wr[31:0];
        r.literal_byte    = lit;
        r.header_src_size = ss[31:0];
        r.header_tgt_size = ts[31:0];
        r.expected_crc    = crc[31:0];
        expected_beats.push_back(r);
    endfunction

    function automatic void flag_error(input bps_pkg::err_t e);
        parse_phase = bps_pkg::PH_ERROR;
        push_beat(bps_pkg::KIND_ERROR, e, 0, 0, 0, 0, 0, 0, 0);
    endfunction

    // relative copy once its offset varint is complete
    function automatic void finish_copy();
        longint unsigned delta;
        longint unsigned base;
        longint unsigned wr;
        bit neg;
        delta = acc >> 1;
        neg   = acc[0];
        wr    = out_pos;
        if (!fits_output(cmd_len)) begin
            flag_error(bps_pkg::ERR_RANGE);
            return;
        end
        base = (cmd_code == bps_pkg::CMD_SOURCE_COPY) ? src_pos : tgt_pos;
        if (neg) begin
            if (delta > base) begin
                flag_error(bps_pkg::ERR_RANGE);
                return;
            end
            base -= delta;
        end else begin
            base += delta;
        end
        if (cmd_code == bps_pkg::CMD_SOURCE_COPY) begin
            if (base > src_limit || cmd_len > longint'(src_limit) - base) begin
                flag_error(bps_pkg::ERR_RANGE);
                return;
            end
            src_pos = (base + cmd_len) & (ADDR_SPAN - 1);
            out_pos += cmd_len;
            parse_phase = bps_pkg::PH_CMD;
            push_beat(bps_pkg::KIND_SOURCE_COPY, bps_pkg::ERR_NONE, cmd_len, base, wr,
                      0, 0, 0, 0);
        end else begin
            if (base >= out_pos) begin
                flag_error(bps_pkg::ERR_RANGE);
                return;
            end
            tgt_pos = (base + cmd_len) & (ADDR_SPAN - 1);
            out_pos += cmd_len;
            parse_phase = bps_pkg::PH_CMD;
            push_beat(bps_pkg::KIND_TARGET_COPY, bps_pkg::ERR_NONE, cmd_len, base, wr,
                      0, 0, 0, 0);
        end
    endfunction

    // one accepted patch beat
    function automatic void decode_byte(input logic [7:0] b, input logic rs);
        logic [31:0]     pos;
        logic [31:0]     footer_start;
        longint unsigned wr;
        longint unsigned ts;
        int              st;
        bit              in_footer;
        if (rs) clear_parse();
        if (parse_phase == bps_pkg::PH_DONE || parse_phase == bps_pkg::PH_ERROR) return;
        pos = byte_count;
        byte_count++;
        footer_start = (patch_len >= bps_pkg::FOOTER_BYTES)
                     ? patch_len - bps_pkg::FOOTER_BYTES : '0;
        in_footer = 0;
        case (parse_phase)
            bps_pkg::PH_MARKER: begin
                if (b != bps_pkg::marker_byte(pos[1:0])) flag_error(bps_pkg::ERR_MARKER);
                else if (pos >= 3) begin
                    parse_phase = bps_pkg::PH_SRC_SIZE;
                    acc = 0;
                    acc_shift = 0;
                end
            end
            bps_pkg::PH_SRC_SIZE: begin
                st = take_varint(b, SIZE_MAX);
                if (st < 0) flag_error(bps_pkg::ERR_OVERFLOW);
                else if (st > 0) begin
                    src_limit = acc[31:0];
                    acc = 0;
                    acc_shift = 0;
                    parse_phase = bps_pkg::PH_TGT_SIZE;
                end
            end
            bps_pkg::PH_TGT_SIZE: begin
                st = take_varint(b, SIZE_MAX);
                if (st < 0) flag_error(bps_pkg::ERR_OVERFLOW);
                else if (st > 0) begin
                    parse_phase = bps_pkg::PH_META_SIZE;
                    ts = acc;
                    acc = 0;
                    acc_shift = 0;
                    push_beat(bps_pkg::KIND_HEADER, bps_pkg::ERR_NONE, 0, 0, 0, 0,
                              src_limit, ts, 0);
                end
            end
            bps_pkg::PH_META_SIZE: begin
                st = take_varint(b, SIZE_MAX);
                if (st < 0) flag_error(bps_pkg::ERR_OVERFLOW);
                else if (st > 0) begin
                    left = acc;
                    acc = 0;
                    acc_shift = 0;
                    parse_phase = (left != 0) ? bps_pkg::PH_META_SKIP : bps_pkg::PH_CMD;
                end
            end
            bps_pkg::PH_META_SKIP: begin
                left--;
                if (left == 0) parse_phase = bps_pkg::PH_CMD;
            end
            bps_pkg::PH_CMD: begin
                if (acc_shift == 0 && pos >= footer_start) begin
                    parse_phase = bps_pkg::PH_FOOTER;
                    footer_idx = 0;
                    acc = 0;
                    acc_shift = 0;
                    in_footer = 1;
                end else begin
                    st = take_varint(b, WORD_MAX);
                    if (st < 0) flag_error(bps_pkg::ERR_OVERFLOW);
                    else if (st > 0) begin
                        cmd_code = acc[1:0];
                        cmd_len  = (acc >> 2) + 1;
                        acc = 0;
                        acc_shift = 0;
                        if (cmd_code == bps_pkg::CMD_SOURCE_READ) begin
                            wr = out_pos;
                            if (!fits_output(cmd_len)) flag_error(bps_pkg::ERR_RANGE);
                            else if (wr > src_limit || cmd_len > longint'(src_limit) - wr)
                                flag_error(bps_pkg::ERR_RANGE);
                            else begin
                                out_pos += cmd_len;
                                push_beat(bps_pkg::KIND_SOURCE_READ, bps_pkg::ERR_NONE,
                                          cmd_len, wr, wr, 0, 0, 0, 0);
                            end
                        end else if (cmd_code == bps_pkg::CMD_TARGET_READ) begin
                            if (!fits_output(cmd_len)) flag_error(bps_pkg::ERR_RANGE);
                            else begin
                                left = cmd_len;
                                parse_phase = bps_pkg::PH_LITERAL;
                            end
                        end else begin
                            parse_phase = bps_pkg::PH_REL;
                        end
                    end
                end
            end
            bps_pkg::PH_FOOTER: in_footer = 1;
            bps_pkg::PH_REL: begin
                st = take_varint(b, DELTA_MAX);
                if (st < 0) flag_error(bps_pkg::ERR_OVERFLOW);
                else if (st > 0) begin
                    finish_copy();
                    acc = 0;
                    acc_shift = 0;
                end
            end
            bps_pkg::PH_LITERAL: begin
                wr = out_pos;
                out_pos++;
                left--;
                if (left == 0) parse_phase = bps_pkg::PH_CMD;
                push_beat(bps_pkg::KIND_LITERAL, bps_pkg::ERR_NONE, 1, 0, wr, b, 0, 0, 0);
            end
            default: flag_error(bps_pkg::ERR_RANGE);
        endcase
        // footer: crc sits in bytes 4..7, little-endian
        if (in_footer) begin
            if (footer_idx >= 4 && footer_idx < 8)
                acc |= longint'(b) << (8 * (footer_idx - 4));
            footer_idx++;
            if (footer_idx >= bps_pkg::FOOTER_BYTES) begin
                parse_phase = bps_pkg::PH_DONE;
                push_beat(bps_pkg::KIND_DONE, bps_pkg::ERR_NONE, 0, 0, 0, 0, 0, 0, acc);
            end
        end
    endfunction

    function automatic bit field_bad(input string name, input longint unsigned want,
                                     input longint unsigned got);
        if (want != got) begin
            $display("%0t: mismatch on %s: expected 0x%0h, actual 0x%0h", $time, name,
                     want, got);
            return 1;
        end
        return 0;
    endfunction

    // observe config, patch beats and result beats
    always @(posedge clk or negedge rst_n) begin
        bps_pkg::result_t want;
        bit bad;
        if (!rst_n) begin
            clear_parse();
            patch_len = '0;
            expected_beats.delete();
            fail_count    <= 0;
            beats_checked <= 0;
            pending       <= 0;
        end else begin
            if (cfg_write_en) patch_len = cfg_write_data;
            if (patch.valid && patch.ready) decode_byte(patch.patch_byte, patch.restart);
            if (result.valid && result.ready) begin
                if (expected_beats.size() == 0) begin
                    $display("%0t: result beat with nothing expected, kind %0d", $time,
                             result.kind);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_beats.pop_front();
                    bad = 0;
                    bad |= field_bad("kind", want.kind, result.kind);
                    bad |= field_bad("error_code", want.error_code, result.error_code);
                    bad |= field_bad("run_length", want.run_length, result.run_length);
                    bad |= field_bad("read_address", want.read_address, result.read_address);
                    bad |= field_bad("write_address", want.write_address,
                                     result.write_address);
                    bad |= field_bad("literal_byte", want.literal_byte, result.literal_byte);
                    bad |= field_bad("header_src_size", want.header_src_size,
                                     result.header_src_size);
                    bad |= field_bad("header_tgt_size", want.header_tgt_size,
                                     result.header_tgt_size);
                    bad |= field_bad("expected_crc", want.expected_crc, result.expected_crc);
                    if (bad) fail_count <= fail_count + 1;
                end
                beats_checked <= beats_checked + 1;
            end
            pending <= expected_beats.size();
        end
    end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        cfg_write_en;
    logic [31:0] cfg_write_data;
    int          fail_count;
    int          beats_checked;
    int          pending;
    int          bytes_sent;
    int          patches_sent;
    int          idle_cycles;
    bit          no_gaps;
    logic [7:0]  patch_bytes[$];

    bps_in_if  patch_ch();
    bps_out_if result_ch();

    bps_patch_stream_decoder_core u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .patch          (patch_ch.sink),
        .result         (result_ch.source)
    );

    bps_decoder_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .patch          (patch_ch),
        .result         (result_ch),
        .fail_count     (fail_count),
        .beats_checked  (beats_checked),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // result sink stalls
    initial
    begin
        int hold;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold > 0) hold--;
            else if (no_gaps || $urandom_range(0, 99) < 60) result_ch.ready = 1'b1;
            else
            begin
                result_ch.ready = 1'b0;
                hold = pick_gap();
            end
        end
    end

    // watchdog on accepted beats
    always @(posedge clk)
    begin
        if (!rst_n || (patch_ch.valid && patch_ch.ready)
            || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // bps varint encoding
    task automatic push_varint(input longint unsigned v);
        forever
        begin
            if ((v >> 7) == 0)
            begin
                patch_bytes.push_back(8'h80 | v[6:0]);
                break;
            end
            patch_bytes.push_back({1'b0, v[6:0]});
            v = (v >> 7) - 1;
        end
    endtask

    task automatic push_marker();
        for (int i = 0; i < 4; i++) patch_bytes.push_back(bps_pkg::marker_byte(i[1:0]));
    endtask

    task automatic push_signed(input longint d);
        if (d < 0) push_varint(((-d) << 1) | 1);
        else push_varint(d << 1);
    endtask

    // enter at a falling edge, leave at a falling edge
    task automatic send_beat(input logic [7:0] b, input logic rs);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            patch_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        patch_ch.valid      = 1'b1;
        patch_ch.patch_byte = b;
        patch_ch.restart    = rs;
        @(posedge clk);
        while (!patch_ch.ready) @(posedge clk);
        bytes_sent++;
        @(negedge clk);
        patch_ch.valid = 1'b0;
    endtask

    // wait for quiet, set the length, then stream the patch
    task automatic send_patch(input logic [31:0] plen);
        patch_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_write_en   = 1'b1;
        cfg_write_data = plen;
        @(negedge clk);
        cfg_write_en   = 1'b0;
        no_gaps = ($urandom_range(0, 5) == 0);
        foreach (patch_bytes[i]) send_beat(patch_bytes[i], i == 0);
        patch_bytes.delete();
        patches_sent++;
    endtask

    // mostly well-formed patch with random content
    task automatic build_patch(output logic [31:0] plen);
        longint unsigned src;
        longint unsigned outp;
        longint unsigned srel;
        longint unsigned trel;
        longint unsigned len;
        longint unsigned rel;
        int c;
        int ncmd;
        int meta;
        src  = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 200) : $urandom_range(0, 20000);
        outp = 0;
        srel = 0;
        trel = 0;
        push_marker();
        push_varint(src);
        push_varint($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 500));
        meta = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
        push_varint(meta);
        repeat (meta) patch_bytes.push_back($urandom_range(0, 255));
        ncmd = $urandom_range(1, 6);
        repeat (ncmd)
        begin
            c   = $urandom_range(0, 3);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
            if (c == bps_pkg::CMD_SOURCE_READ && outp + len > src) c = bps_pkg::CMD_TARGET_READ;
            if (c == bps_pkg::CMD_SOURCE_COPY && len > src) c = bps_pkg::CMD_TARGET_READ;
            if (c == bps_pkg::CMD_TARGET_COPY && outp == 0) c = bps_pkg::CMD_TARGET_READ;
            if ($urandom_range(0, 12) == 0)
            begin
                // noise word
                repeat ($urandom_range(1, 3)) patch_bytes.push_back($urandom_range(0, 255));
                continue;
            end
            push_varint(((len - 1) << 2) | c);
            case (c)
                bps_pkg::CMD_SOURCE_READ: outp += len;
                bps_pkg::CMD_TARGET_READ:
                begin
                    repeat (len) patch_bytes.push_back($urandom_range(0, 255));
                    outp += len;
                end
                bps_pkg::CMD_SOURCE_COPY:
                begin
                    rel = $urandom_range(0, src - len);
                    push_signed(longint'(rel) - longint'(srel));
                    srel = rel + len;
                    outp += len;
                end
                default:
                begin
                    rel = $urandom_range(0, outp - 1);
                    push_signed(longint'(rel) - longint'(trel));
                    trel = rel + len;
                    outp += len;
                end
            endcase
        end
        repeat (bps_pkg::FOOTER_BYTES) patch_bytes.push_back($urandom_range(0, 255));
        plen = patch_bytes.size();
        if ($urandom_range(0, 9) == 0) plen = $urandom_range(0, patch_bytes.size() + 4);
        if ($urandom_range(0, 19) == 0)
            patch_bytes[$urandom_range(0, patch_bytes.size() - 1)] = $urandom_range(0, 255);
    endtask

    initial
    begin
        logic [31:0] plen;
        rst_n               = 1'b0;
        cfg_write_en        = 1'b0;
        cfg_write_data      = '0;
        patch_ch.valid      = 1'b0;
        patch_ch.patch_byte = '0;
        patch_ch.restart    = 1'b0;
        no_gaps             = 1'b0;
        bytes_sent          = 0;
        patches_sent        = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // bad marker
        patch_bytes = '{8'h42, 8'h00};
        send_patch('0);
        // size varint overflow
        push_marker();
        repeat (6) patch_bytes.push_back(8'h7F);
        send_patch('0);
        // largest header sizes, one source read, then the footer
        push_marker();
        push_varint(64'hFFFF_FFFF);
        push_varint(64'hFFFF_FFFF);
        push_varint(0);
        push_varint({bps_pkg::CMD_SOURCE_READ});
        patch_bytes = {patch_bytes, 8'hFF, 8'h00, 8'h7F, 8'h80, 8'h01, 8'h02, 8'h03, 8'h04,
                       8'hAA, 8'h55, 8'hFE, 8'hEF};
        send_patch(patch_bytes.size());
        // source copy going below zero
        push_marker();
        push_varint(10);
        push_varint(10);
        push_varint(0);
        push_varint({bps_pkg::CMD_SOURCE_COPY});
        push_signed(-1);
        send_patch(32'hFFFF_FFFF);

        // random patches
        while (bytes_sent < 450)
        begin
            build_patch(plen);
            send_patch(plen);
        end

        patch_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        $display("testbench: %0d patches, %0d bytes streamed, %0d result beats checked",
                 patches_sent, bytes_sent, beats_checked);
        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

FILE: sim.f
rtl/bps_pkg.sv
rtl/bps_in_if.sv
rtl/bps_out_if.sv
rtl/bps_patch_stream_decoder_core.sv
dv/bps_decoder_checker.sv
dv/testbench.sv
